/* hdl/lbcg_pkg.sv */
`default_nettype none

package lbcg_pkg;

    localparam int MAX_CORES_DEF = 4;

    // Count width that the table lane selectors accept (counts up to fifteen).
    localparam int LANE_IDX_W = 4;

    localparam logic [15:0] RESUME_DELAY_MS = 16'd2500;
    localparam logic [7:0]  DWELL_MAX       = 8'hFF;

    localparam logic [15:0] ALL_MARK_RST  = 16'd800;
    localparam logic [63:0] EN_THR_RST    = 64'h0000_0154_00DC_0078;
    localparam logic [63:0] DIS_THR_RST   = 64'h0104_0078_003C_0000;
    localparam logic [63:0] DELAYS_RST    = 64'h0032_0064_0032_0019;
    localparam logic [31:0] ON_DWELL_RST  = 32'h0005_0303;
    localparam logic [31:0] OFF_DWELL_RST = 32'h0403_0800;
    localparam logic [2:0]  MIN_ON_RST    = 3'd1;
    localparam logic [2:0]  AVAIL_RST     = 3'd4;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_SUSPEND = 2'd1,
        CMD_RESUME  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_ONE_OFF   = 3'd1,
        ACT_ONE_ON    = 3'd2,
        ACT_ALL_ON    = 3'd3,
        ACT_SUSPENDED = 3'd4,
        ACT_RESUMED   = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        REG_ALL_MARK  = 3'd0,
        REG_EN_THR    = 3'd1,
        REG_DIS_THR   = 3'd2,
        REG_DELAYS    = 3'd3,
        REG_ON_DWELL  = 3'd4,
        REG_OFF_DWELL = 3'd5,
        REG_MIN_ON    = 3'd6,
        REG_AVAIL     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] load;
    } t_in;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  online_count;
        logic [15:0] next_delay_ms;
    } t_out;

    typedef struct packed {
        logic [15:0] enable_all_threshold;
        logic [63:0] enable_thresholds;
        logic [63:0] disable_thresholds;
        logic [63:0] sample_delays;
        logic [31:0] online_dwell_periods;
        logic [31:0] offline_dwell_periods;
        logic [2:0]  min_online;
        logic [2:0]  cores_available;
    } t_cfg;

    // Lane k belongs to online count k+1; other counts read zero.
    function automatic logic [15:0] lane16(input logic [63:0] tbl,
                                           input logic [LANE_IDX_W-1:0] cnt);
        logic [15:0] v;
        case (cnt)
            4'd1:    v = tbl[15:0];
            4'd2:    v = tbl[31:16];
            4'd3:    v = tbl[47:32];
            4'd4:    v = tbl[63:48];
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] lane8(input logic [31:0] tbl,
                                         input logic [LANE_IDX_W-1:0] cnt);
        logic [7:0] v;
        case (cnt)
            4'd1:    v = tbl[7:0];
            4'd2:    v = tbl[15:8];
            4'd3:    v = tbl[23:16];
            4'd4:    v = tbl[31:24];
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == DWELL_MAX) ? DWELL_MAX : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

/* hdl/lbcg_cfg.sv */
`default_nettype none

module lbcg_cfg
    import lbcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  wire logic [2:0]  i_index,
    input  wire logic [63:0] i_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_all_threshold  <= ALL_MARK_RST;
            r_cfg.enable_thresholds     <= EN_THR_RST;
            r_cfg.disable_thresholds    <= DIS_THR_RST;
            r_cfg.sample_delays         <= DELAYS_RST;
            r_cfg.online_dwell_periods  <= ON_DWELL_RST;
            r_cfg.offline_dwell_periods <= OFF_DWELL_RST;
            r_cfg.min_online            <= MIN_ON_RST;
            r_cfg.cores_available       <= AVAIL_RST;
        end else if (i_wr) begin
            case (i_index)
                REG_ALL_MARK:  r_cfg.enable_all_threshold  <= i_data[15:0];
                REG_EN_THR:    r_cfg.enable_thresholds     <= i_data;
                REG_DIS_THR:   r_cfg.disable_thresholds    <= i_data;
                REG_DELAYS:    r_cfg.sample_delays         <= i_data;
                REG_ON_DWELL:  r_cfg.online_dwell_periods  <= i_data[31:0];
                REG_OFF_DWELL: r_cfg.offline_dwell_periods <= i_data[31:0];
                REG_MIN_ON:    r_cfg.min_online            <= i_data[2:0];
                REG_AVAIL:     r_cfg.cores_available       <= i_data[2:0];
                default:       r_cfg.min_online            <= r_cfg.min_online;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hdl/lbcg_core.sv */
`default_nettype none

module lbcg_core
    import lbcg_pkg::*;
#(
    parameter int MAX_CORES = MAX_CORES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_in  i_item,
    input  wire t_cfg i_cfg,
    output t_out      o_res
);

    localparam int CNT_W = $clog2(MAX_CORES + 1);
    localparam int CW    = (CNT_W > 3) ? CNT_W : 3;

    logic [CNT_W-1:0] r_cores, n_cores;
    logic [7:0]       r_up, n_up;
    logic [7:0]       r_down, n_down;
    logic             r_susp, n_susp;

    logic [CW-1:0]    cnt_x, minc, avail, avail_raw;
    logic [15:0]      all_mark, en_mark, dis_mark;
    logic [7:0]       on_per, off_per;
    logic             load_all, down_hit, up_hit;
    logic [2:0]       action;
    logic [15:0]      delay;

    always_comb begin
        cnt_x     = CW'(r_cores);
        minc      = (i_cfg.min_online == 3'd0) ? CW'(1) : CW'(i_cfg.min_online);
        avail_raw = (i_cfg.cores_available == 3'd0) ? CW'(1)
                                                    : CW'(i_cfg.cores_available);
        avail     = (avail_raw > CW'(MAX_CORES)) ? CW'(MAX_CORES) : avail_raw;
        all_mark  = i_cfg.enable_all_threshold;
        en_mark   = lane16(i_cfg.enable_thresholds, LANE_IDX_W'(r_cores));
        dis_mark  = lane16(i_cfg.disable_thresholds, LANE_IDX_W'(r_cores));
        on_per    = lane8(i_cfg.online_dwell_periods, LANE_IDX_W'(r_cores));
        off_per   = lane8(i_cfg.offline_dwell_periods, LANE_IDX_W'(r_cores));
        load_all  = i_item.load >= all_mark;
        down_hit  = (i_item.load <= dis_mark) && (cnt_x > minc);
        up_hit    = !down_hit && (load_all || i_item.load >= en_mark) && (cnt_x < avail);
    end

    always_comb begin
        n_cores = r_cores;
        n_up    = r_up;
        n_down  = r_down;
        n_susp  = r_susp;
        action  = ACT_NONE;
        delay   = r_susp ? 16'd0 : lane16(i_cfg.sample_delays, LANE_IDX_W'(r_cores));
        if (i_item.cmd == CMD_SUSPEND) begin
            n_cores = CNT_W'(1);
            n_susp  = 1'b1;
            action  = ACT_SUSPENDED;
            delay   = 16'd0;
        end else if (i_item.cmd == CMD_RESUME) begin
            if (r_cores < CNT_W'(2)) begin
                n_cores = CNT_W'(2);
            end
            n_up   = 8'd1;
            n_down = 8'd1;
            n_susp = 1'b0;
            action = ACT_RESUMED;
            delay  = RESUME_DELAY_MS;
        end else if (i_item.cmd == CMD_SAMPLE && !r_susp) begin
            if (down_hit) begin
                if (r_down >= off_per) begin
                    n_cores = r_cores - CNT_W'(1);
                    n_down  = 8'd1;
                    action  = ACT_ONE_OFF;
                end else begin
                    n_down = bump(r_down);
                end
                n_up = 8'd1;
            end else if (up_hit) begin
                if (r_up >= on_per) begin
                    if (load_all) begin
                        n_cores = CNT_W'(avail);
                        action  = ACT_ALL_ON;
                    end else begin
                        n_cores = r_cores + CNT_W'(1);
                        action  = ACT_ONE_ON;
                    end
                    n_up = 8'd1;
                end else begin
                    n_up = bump(r_up);
                end
                n_down = 8'd1;
            end
            delay = lane16(i_cfg.sample_delays, LANE_IDX_W'(n_cores));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cores <= CNT_W'(MAX_CORES);
            r_up    <= 8'd0;
            r_down  <= 8'd0;
            r_susp  <= 1'b0;
        end else if (i_fire) begin
            r_cores <= n_cores;
            r_up    <= n_up;
            r_down  <= n_down;
            r_susp  <= n_susp;
        end
    end

    assign o_res.action        = action;
    assign o_res.online_count  = 3'(n_cores);
    assign o_res.next_delay_ms = delay;

endmodule

`default_nettype wire

/* hdl/load_based_core_count_governor_top.sv */
// Load-based core count governor. Each request carries a command (load
// sample, suspend or resume) and a load figure; each one yields exactly one
// result with the action taken, the online core count afterwards and the
// delay before the next sample. A request enters an input register; once the
// result register is free, the decision logic reads the held state (online
// count, two saturating dwell counters, suspended flag) and the configuration
// tables, updates the state and loads the result register. One request per
// cycle is taken for as long as results are drained; the state update made
// as each request is decided is what sets that rate. Configuration writes are
// taken every cycle and must only be issued while no request is in flight.
`default_nettype none

module load_based_core_count_governor_top
    import lbcg_pkg::*;
#(
    parameter int MAX_CORES = MAX_CORES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    t_cfg cfg;
    t_out res;

    logic r_in_valid;
    t_in  r_in_data;
    logic r_out_valid;
    t_out r_out_data;

    logic out_free;
    logic dec_fire;

    // Result stage can take a new result when empty or being drained.
    assign out_free    = !r_out_valid || i_out_ready;
    assign dec_fire    = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    lbcg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lbcg_core #(
        .MAX_CORES (MAX_CORES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (dec_fire),
        .i_item  (r_in_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Input register: advance whenever the decision stage moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register: hold while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_fire) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* hdl/lbcg_checker.sv */
`default_nettype none

module lbcg_checker
    import lbcg_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out_data
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // Requests are only refused while a result is waiting.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("request refused with room in the pipeline");

    a_suspend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.action == ACT_SUSPENDED
        |-> o_out_data.online_count == 3'd1 && o_out_data.next_delay_ms == 16'd0)
        else $error("suspend result malformed");

    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.action == ACT_RESUMED
        |-> o_out_data.next_delay_ms == RESUME_DELAY_MS && o_out_data.online_count != 3'd1)
        else $error("resume result malformed");

endmodule

bind load_based_core_count_governor_top lbcg_checker u_lbcg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

/* verif/load_based_core_count_governor_top_test.sv */
`timescale 1ns / 100ps

module load_based_core_count_governor_top_test;
    import lbcg_pkg::*;

    // Command code with no meaning to the block; it must change nothing.
    localparam logic [1:0] CMD_UNDEF = 2'd3;

    localparam int CORES           = MAX_CORES_DEF;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int SCRIPT_ROWS     = 25;
    localparam int LIMIT_CYCLES    = 200000;

    localparam t_out NO_RESULT = '0;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data  = '0;

    load_based_core_count_governor_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Governor shadow: configuration and state as the block should hold
    // them after every accepted request and register write.
    // ------------------------------------------------------------------
    t_cfg gov_cfg = '{ALL_MARK_RST, EN_THR_RST, DIS_THR_RST, DELAYS_RST,
                      ON_DWELL_RST, OFF_DWELL_RST, MIN_ON_RST, AVAIL_RST};

    int unsigned cores_on   = CORES;
    logic [7:0]  up_dwell   = 8'd0;
    logic [7:0]  down_dwell = 8'd0;
    bit          suspended  = 1'b0;

    // Expected results, oldest first.
    t_out pending_results [$];
    int   mismatch_cnt = 0;
    int   cycle_cnt    = 0;

    // Idle and stall odds, in percent per cycle.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Load generator state: runs of similar loads walk the dwell counters.
    int burst_left = 0;
    int regime     = 0;

    // Lane k of a packed table belongs to online count k+1; other counts read zero.
    function automatic logic [15:0] mark16(logic [63:0] tbl, int unsigned c);
        if (c < 1 || c > 4)
            return 16'd0;
        return tbl[16*(c-1) +: 16];
    endfunction

    function automatic logic [7:0] period8(logic [31:0] tbl, int unsigned c);
        if (c < 1 || c > 4)
            return 8'd0;
        return tbl[8*(c-1) +: 8];
    endfunction

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Apply one request to the shadow state and return the decision it yields.
    function automatic t_out govern_step(t_in req);
        t_out        res;
        int unsigned floor_cnt;
        int unsigned ceil_cnt;
        int unsigned cnt;
        logic [15:0] all_mark;
        floor_cnt = (gov_cfg.min_online < 3'd1) ? 1 : gov_cfg.min_online;
        ceil_cnt  = (gov_cfg.cores_available < 3'd1) ? 1 : gov_cfg.cores_available;
        if (ceil_cnt > CORES)
            ceil_cnt = CORES;
        all_mark   = gov_cfg.enable_all_threshold;
        cnt        = cores_on;
        res.action = ACT_NONE;
        if (req.cmd == CMD_SUSPEND) begin
            cores_on  = 1;
            suspended = 1'b1;
            res.action        = ACT_SUSPENDED;
            res.next_delay_ms = 16'd0;
        end else if (req.cmd == CMD_RESUME) begin
            if (cores_on < 2)
                cores_on = 2;
            up_dwell   = 8'd1;
            down_dwell = 8'd1;
            suspended  = 1'b0;
            res.action        = ACT_RESUMED;
            res.next_delay_ms = RESUME_DELAY_MS;
        end else if (req.cmd == CMD_SAMPLE && !suspended) begin
            if (req.load <= mark16(gov_cfg.disable_thresholds, cnt) && cnt > floor_cnt) begin
                if (down_dwell >= period8(gov_cfg.offline_dwell_periods, cnt)) begin
                    cnt        = cnt - 1;
                    down_dwell = 8'd0;
                    res.action = ACT_ONE_OFF;
                end
                down_dwell = sat_inc(down_dwell);
                up_dwell   = 8'd1;
            end else if ((req.load >= all_mark ||
                          req.load >= mark16(gov_cfg.enable_thresholds, cnt)) &&
                         cnt < ceil_cnt) begin
                if (up_dwell >= period8(gov_cfg.online_dwell_periods, cnt)) begin
                    if (req.load >= all_mark) begin
                        cnt        = ceil_cnt;
                        res.action = ACT_ALL_ON;
                    end else begin
                        cnt        = cnt + 1;
                        res.action = ACT_ONE_ON;
                    end
                    up_dwell = 8'd0;
                end
                up_dwell   = sat_inc(up_dwell);
                down_dwell = 8'd1;
            end
            cores_on          = cnt;
            res.next_delay_ms = mark16(gov_cfg.sample_delays, cnt);
        end else begin
            // Sample while suspended, or an unknown command: hold everything.
            res.next_delay_ms = suspended ? 16'd0 : mark16(gov_cfg.sample_delays, cores_on);
        end
        res.online_count = cores_on[2:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Directed script. Rows with a typed result are read straight off the
    // rules; the rest are checked against the shadow.
    // ------------------------------------------------------------------
    typedef struct {
        t_in  req;
        bit   known;
        t_out result;
    } t_script_row;

    t_script_row script [SCRIPT_ROWS] = '{
        // Right after reset: all four cores on, mid load moves nothing.
        '{'{CMD_SAMPLE,  16'd500},    1'b1, '{ACT_NONE, 3'd4, 16'd50}},
        // Idle load until the remove dwell runs out and one core drops.
        '{'{CMD_SAMPLE,  16'd0},      1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd0},      1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd0},      1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd0},      1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd0},      1'b0, NO_RESULT},
        // Full-scale load starts the add dwell.
        '{'{CMD_SAMPLE,  16'hFFFF},   1'b0, NO_RESULT},
        // Suspend, then a sample and an unknown command while suspended.
        '{'{CMD_SUSPEND, 16'd0},      1'b1, '{ACT_SUSPENDED, 3'd1, 16'd0}},
        '{'{CMD_SAMPLE,  16'hFFFF},   1'b1, '{ACT_NONE, 3'd1, 16'd0}},
        '{'{CMD_UNDEF,   16'h5A5A},   1'b1, '{ACT_NONE, 3'd1, 16'd0}},
        '{'{CMD_RESUME,  16'hA5A5},   1'b1, '{ACT_RESUMED, 3'd2, RESUME_DELAY_MS}},
        // Unknown command while running reports the table delay.
        '{'{CMD_UNDEF,   16'd0},      1'b1, '{ACT_NONE, 3'd2, 16'd50}},
        // Resume while already running.
        '{'{CMD_RESUME,  16'd0},      1'b1, '{ACT_RESUMED, 3'd2, RESUME_DELAY_MS}},
        // Load exactly at the enable-all mark: all cores on after the dwell.
        '{'{CMD_SAMPLE,  16'd800},    1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd800},    1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd800},    1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd0},      1'b0, NO_RESULT},
        // Back to two cores, then load exactly at the add mark: one core on.
        '{'{CMD_SUSPEND, 16'd0},      1'b0, NO_RESULT},
        '{'{CMD_RESUME,  16'd0},      1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd220},    1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd220},    1'b0, NO_RESULT},
        '{'{CMD_SAMPLE,  16'd220},    1'b0, NO_RESULT},
        // Load exactly at the remove mark counts toward removal.
        '{'{CMD_SAMPLE,  16'd120},    1'b0, NO_RESULT},
        '{'{CMD_SUSPEND, 16'hFFFF},   1'b1, '{ACT_SUSPENDED, 3'd1, 16'd0}},
        '{'{CMD_RESUME,  16'd0},      1'b1, '{ACT_RESUMED, 3'd2, RESUME_DELAY_MS}}
    };

    // Pick a register value: all zeros, all ones, or a plausible random setting.
    // Bits above a register's width are left random; the block must drop them.
    function automatic logic [63:0] pick_setting(t_reg_idx idx, int ph);
        logic [63:0] v;
        int          r;
        if (ph == 2)
            return '0;
        if (ph == 3)
            return '1;
        v = {$urandom, $urandom};
        case (idx)
            REG_ALL_MARK: begin
                v[15:0] = ($urandom_range(99) < 20) ? 16'($urandom) : 16'($urandom_range(1500));
            end
            REG_EN_THR, REG_DIS_THR, REG_DELAYS: begin
                for (int k = 0; k < 4; k++) begin
                    r = $urandom_range(99);
                    v[16*k +: 16] = (r < 15) ? 16'($urandom) : 16'($urandom_range(1000));
                end
            end
            REG_ON_DWELL, REG_OFF_DWELL: begin
                for (int k = 0; k < 4; k++) begin
                    r = $urandom_range(99);
                    if (r < 10)
                        v[8*k +: 8] = 8'hFF;
                    else if (r < 20)
                        v[8*k +: 8] = 8'($urandom);
                    else
                        v[8*k +: 8] = 8'($urandom_range(6));
                end
            end
            REG_MIN_ON: begin
                v[2:0] = ($urandom_range(99) < 60) ? 3'($urandom_range(2, 1))
                                                  : 3'($urandom_range(7));
            end
            REG_AVAIL: begin
                v[2:0] = ($urandom_range(99) < 60) ? 3'($urandom_range(4, 3))
                                                  : 3'($urandom_range(7));
            end
            default: ;
        endcase
        return v;
    endfunction

    // Next random request. Mostly samples in runs of one load band, so the
    // dwell counters get walked to their periods; the rest is commands and noise.
    function automatic t_in next_request();
        t_in         req;
        int          r;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] all_mark;
        r        = $urandom_range(99);
        all_mark = gov_cfg.enable_all_threshold;
        req.load = 16'($urandom);
        if (suspended) begin
            if (r < 70)
                req.cmd = CMD_RESUME;
            else if (r < 85)
                req.cmd = CMD_SAMPLE;
            else if (r < 93)
                req.cmd = CMD_SUSPEND;
            else
                req.cmd = CMD_UNDEF;
            return req;
        end
        if (r < 3) begin
            req.cmd = CMD_SUSPEND;
        end else if (r < 6) begin
            req.cmd = CMD_RESUME;
        end else if (r < 9) begin
            req.cmd = CMD_UNDEF;
        end else begin
            req.cmd = CMD_SAMPLE;
            if (burst_left == 0) begin
                regime     = $urandom_range(4);
                burst_left = $urandom_range(40, 1);
            end
            burst_left--;
            case (regime)
                0: req.load = 16'($urandom_range(mark16(gov_cfg.disable_thresholds, cores_on)));
                1: begin
                    lo = mark16(gov_cfg.enable_thresholds, cores_on);
                    hi = (all_mark > lo) ? all_mark - 16'd1 : lo;
                    req.load = 16'($urandom_range(hi, lo));
                end
                2: req.load = 16'($urandom_range(16'hFFFF, all_mark));
                3: req.load = 16'($urandom_range(2000));
                default: ;
            endcase
        end
        return req;
    endfunction

    // Drive one request, honoring the sender idle odds; record the expected
    // result at the edge that accepts it.
    task automatic send_request(t_in req, bit known, t_out typed);
        t_out predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = govern_step(req);
        pending_results.push_back(known ? typed : predicted);
    endtask

    // Write one register and mirror it into the shadow once accepted.
    task automatic cfg_write(t_reg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ALL_MARK:  gov_cfg.enable_all_threshold  = val[15:0];
            REG_EN_THR:    gov_cfg.enable_thresholds     = val;
            REG_DIS_THR:   gov_cfg.disable_thresholds    = val;
            REG_DELAYS:    gov_cfg.sample_delays         = val;
            REG_ON_DWELL:  gov_cfg.online_dwell_periods  = val[31:0];
            REG_OFF_DWELL: gov_cfg.offline_dwell_periods = val[31:0];
            REG_MIN_ON:    gov_cfg.min_online            = val[2:0];
            REG_AVAIL:     gov_cfg.cores_available       = val[2:0];
            default: ;
        endcase
    endtask

    // Drop both valids, wait out every expected result, then the pipeline depth.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Receiver: stall at random with the current odds.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: action %0d online_count %0d delay %0d",
                       o_out_data.action, o_out_data.online_count,
                       o_out_data.next_delay_ms);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, o_out_data.action);
                    mismatch_cnt++;
                end
                if (o_out_data.online_count !== want.online_count) begin
                    $error("online_count: expected %0d, got %0d",
                           want.online_count, o_out_data.online_count);
                    mismatch_cnt++;
                end
                if (o_out_data.next_delay_ms !== want.next_delay_ms) begin
                    $error("next_delay_ms: expected %0d, got %0d",
                           want.next_delay_ms, o_out_data.next_delay_ms);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: abandon a run that hangs.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed script, then one random phase per setting.
    initial begin
        int  kept;
        t_in req;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r])
            send_request(script[r].req, script[r].known, script[r].result);
        settle();

        // Phase 0 keeps the reset setting, 2 zeros every register, 3 sets every bit.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                for (int r = 0; r < 8; r++)
                    cfg_write(t_reg_idx'(r), pick_setting(t_reg_idx'(r), ph));
                settle();
            end
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 60;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 60;
                end
                default: begin
                    send_idle_pct = 21;
                    stall_pct     = 21;
                end
            endcase
            kept = 0;
            while (kept < ITEMS_PER_PHASE) begin
                req = next_request();
                // Count only requests the block acts on.
                if (!(req.cmd == CMD_UNDEF || (req.cmd == CMD_SAMPLE && suspended)))
                    kept++;
                send_request(req, 1'b0, NO_RESULT);
            end
            settle();
        end

        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
